// ===== hdl/cst_pkg.sv =====
package cst_pkg;

  localparam int NUM_SEMS_DEF  = 256;
  localparam int NUM_PROCS_DEF = 32;
  localparam int MAX_OUT       = 32;
  localparam logic [14:0] COUNT_MAX = 15'h7fff;

  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_WAIT   = 2'd1,
    OP_SIGNAL = 2'd2,
    OP_FREE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BLOCKED   = 3'd1,
    ST_FULL      = 3'd2,
    ST_BAD_INIT  = 3'd3,
    ST_BAD_ID    = 3'd4,
    ST_SATURATED = 3'd5
  } status_t;

  typedef struct packed {
    logic [1:0]         op;
    logic [9:0]         sem_id;
    logic signed [15:0] init_value;
    logic [4:0]         proc_slot;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] result_sem;
    logic       wake_valid;
    logic [4:0] woken_slot;
    logic       wake_reason;
    logic       had_waiters;
    logic       last;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_READ,
    S_HEAD,
    S_EXEC,
    S_WALK_RD,
    S_WALK,
    S_OUT
  } fsm_t;

endpackage

// ===== hdl/counting_semaphore_table.sv =====
// Counting semaphore table with a FIFO wait queue per semaphore.
// P/V/free pass S_READ, S_HEAD and S_EXEC to a result in S_OUT; a bad id goes
//   S_READ to S_OUT, a bad init straight to S_OUT; create scans up to NUM_SEMS
//   slots, one in_use test a cycle. Free emits one result per waiter, up to LIMIT.
// One request at a time; in_ready high only when idle.
// Reset (rst, sync) clears control and valid bits; RAM contents stay unknown.
module counting_semaphore_table #(
  parameter int NUM_SEMS  = cst_pkg::NUM_SEMS_DEF,
  parameter int NUM_PROCS = cst_pkg::NUM_PROCS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  cst_pkg::req_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output cst_pkg::rsp_t out_data
);
  import cst_pkg::*;

  localparam int SW = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
  localparam int PW = $clog2(NUM_PROCS);
  localparam int EW = 1 + PW + PW + 15;  // nonempty, head, tail, count
  localparam int LIMIT = (NUM_PROCS < MAX_OUT) ? NUM_PROCS : MAX_OUT;

  // Per-slot valid bits in flip-flops: reset clears them at once.
  logic [NUM_SEMS-1:0] in_use;

  fsm_t state, state_next;
  req_t req;
  logic [SW-1:0] idx;
  logic [5:0] cnt;
  logic [PW-1:0] cur;
  rsp_t rsp;
  logic [EW-1:0] ent;
  rsp_t exec_rsp, walk_rsp;

  // entry RAM: {nonempty, head, tail, count}
  logic          e_we;
  logic [SW-1:0] e_waddr, e_raddr;
  logic [EW-1:0] e_wdata, e_rdata;
  // next_waiter RAM
  logic          n_we;
  logic [PW-1:0] n_waddr, n_raddr, n_wdata, n_rdata;

  cst_ram #(.WIDTH(EW), .DEPTH(NUM_SEMS)) u_ent (
    .clk, .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(e_raddr), .rdata(e_rdata));
  cst_ram #(.WIDTH(PW), .DEPTH(NUM_PROCS)) u_nxt (
    .clk, .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
    .raddr(n_raddr), .rdata(n_rdata));

  logic          e_ne;
  logic [PW-1:0] e_hd, e_tl;
  logic [14:0]   e_ct;
  logic [PW-1:0] proc_m;
  logic          id_ok;

  // proc_slot modulo NUM_PROCS by compare and subtract
  function automatic logic [PW-1:0] proc_mod(logic [4:0] p);
    logic [11:0] r;
    r = 12'(p);
    for (int k = 4; k >= 0; k--)
      if (r >= 12'(NUM_PROCS << k)) r = r - 12'(NUM_PROCS << k);
    return PW'(r);
  endfunction

  assign {e_ne, e_hd, e_tl, e_ct} = e_rdata;
  assign proc_m = proc_mod(req.proc_slot);
  assign id_ok  = (32'(req.sem_id) < NUM_SEMS) && in_use[req.sem_id[SW-1:0]];
  assign e_raddr = idx;
  // head read of next_waiter for signal, then walk reads
  assign n_raddr = (state == S_HEAD) ? e_hd : cur;
  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign out_data  = rsp;

  function automatic rsp_t mk(status_t s, logic [7:0] sem);
    rsp_t r;
    r = '0;
    r.status = s;
    r.result_sem = sem;
    r.last = 1'b1;
    return r;
  endfunction

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) begin
        if (in_data.op == OP_CREATE) state_next = in_data.init_value[15] ? S_OUT : S_SCAN;
        else state_next = S_READ;
      end
      S_SCAN: if (!in_use[idx] || 32'(idx) == NUM_SEMS - 1) state_next = S_OUT;
      S_READ: state_next = id_ok ? S_HEAD : S_OUT;
      S_HEAD: state_next = S_EXEC;
      S_EXEC: state_next = S_OUT;
      S_WALK_RD: state_next = S_WALK;
      S_WALK: state_next = S_OUT;
      S_OUT: if (out_ready) state_next = rsp.last ? S_IDLE : S_WALK_RD;
      default: state_next = S_IDLE;
    endcase
  end

  // memory write control
  always_comb begin
    e_we = 1'b0; e_waddr = idx; e_wdata = e_rdata;
    n_we = 1'b0; n_waddr = e_tl; n_wdata = proc_m;
    case (state)
      S_SCAN: if (!in_use[idx]) begin
        e_we = 1'b1;
        e_wdata = {1'b0, e_hd, e_tl, req.init_value[14:0]};
      end
      S_EXEC: begin
        e_we = 1'b1;
        case (op_t'(req.op))
          OP_WAIT: if (e_ct != '0) e_wdata = {e_ne, e_hd, e_tl, e_ct - 15'd1};
            else begin
              e_wdata = {1'b1, e_ne ? e_hd : proc_m, proc_m, e_ct};
              n_we = e_ne;
            end
          OP_SIGNAL: if (e_ne) begin
              e_wdata = (e_hd == e_tl) ? {1'b0, e_hd, e_tl, e_ct}
                                       : {1'b1, n_rdata, e_tl, e_ct};
            end else if (e_ct != COUNT_MAX) e_wdata = {e_ne, e_hd, e_tl, e_ct + 15'd1};
          OP_FREE: e_wdata = {1'b0, e_hd, e_tl, 15'd0};
          default: e_we = 1'b0;
        endcase
      end
      default: ;
    endcase
  end

  // result of the update step and of each walk step
  always_comb begin
    exec_rsp = mk(ST_OK, req.sem_id[7:0]);
    case (op_t'(req.op))
      OP_WAIT: if (e_ct == '0) exec_rsp.status = ST_BLOCKED;
      OP_SIGNAL: if (e_ne) begin
          exec_rsp.wake_valid = 1'b1;
          exec_rsp.woken_slot = 5'(e_hd);
        end else if (e_ct == COUNT_MAX) exec_rsp.status = ST_SATURATED;
      OP_FREE: if (e_ne) begin
          exec_rsp.wake_valid = 1'b1; exec_rsp.woken_slot = 5'(e_hd);
          exec_rsp.wake_reason = 1'b1; exec_rsp.had_waiters = 1'b1;
          exec_rsp.last = (e_hd == e_tl) || (LIMIT <= 1);
        end
      default: ;
    endcase
    walk_rsp = rsp;
    walk_rsp.woken_slot = 5'(n_rdata);
    walk_rsp.last = (n_rdata == ent[15+PW-1:15]) || (32'(cnt) + 1 >= LIMIT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      in_use <= '0;
    end else begin
      state <= state_next;
      if (state == S_SCAN && !in_use[idx]) in_use[idx] <= 1'b1;
      if (state == S_EXEC && req.op == OP_FREE) in_use[idx] <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: if (in_valid) begin
        req <= in_data;
        idx <= (in_data.op == OP_CREATE) ? '0 : in_data.sem_id[SW-1:0];
        cnt <= 6'd0;
        if (in_data.init_value[15] && in_data.op == OP_CREATE)
          rsp <= mk(ST_BAD_INIT, 8'd0);
      end
      S_SCAN: if (!in_use[idx]) rsp <= mk(ST_OK, 8'(idx));
        else if (32'(idx) == NUM_SEMS - 1) rsp <= mk(ST_FULL, 8'd0);
        else idx <= idx + SW'(1);
      S_READ: if (!id_ok) rsp <= mk(ST_BAD_ID, req.sem_id[7:0]);
      S_EXEC: begin
        rsp <= exec_rsp;
        ent <= e_rdata;
        if (req.op == OP_FREE && e_ne) cnt <= 6'd1;
      end
      S_WALK: begin
        rsp <= walk_rsp;
        cnt <= cnt + 6'd1;
      end
      S_OUT: if (out_ready && !rsp.last) cur <= PW'(rsp.woken_slot);
      default: ;
    endcase
  end

  a_one_hot_handshake: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("in and out both open");
  a_walk_freed: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> req.op == OP_FREE) else $error("walk on non-free");
  a_bad_init: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status == ST_BAD_INIT) |-> req.op == OP_CREATE)
    else $error("bad init on non-create");
endmodule

// ===== hdl/cst_ram.sv =====
module cst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== verif/counting_semaphore_table_tb.sv =====
`timescale 1ns / 1ps

// Semaphore table predictor plus ordered result checker.
class sem_scoreboard;
  localparam int NSEM  = cst_pkg::NUM_SEMS_DEF;
  localparam int NPROC = cst_pkg::NUM_PROCS_DEF;

  bit          in_use[NSEM];
  logic [14:0] count[NSEM];
  bit          has_waiters[NSEM];
  logic [4:0]  head[NSEM];
  logic [4:0]  tail[NSEM];
  logic [4:0]  next_proc[NPROC];
  cst_pkg::rsp_t pending[$];
  int errors;

  function void push(int st, int sem, int wk, int slot, int reason, int had, int lst);
    cst_pkg::rsp_t r;
    r.status = 3'(st); r.result_sem = 8'(sem); r.wake_valid = 1'(wk);
    r.woken_slot = 5'(slot); r.wake_reason = 1'(reason); r.had_waiters = 1'(had);
    r.last = 1'(lst);
    pending.push_back(r);
  endfunction

  // Predict the result items of one accepted request.
  function void note_request(cst_pkg::req_t q);
    int s, n;
    logic [9:0] id;
    logic [4:0] cur, p;
    bit fin;
    id = q.sem_id;
    p = q.proc_slot;
    if (q.op == cst_pkg::OP_CREATE) begin
      if (q.init_value < 0) begin
        push(cst_pkg::ST_BAD_INIT, 0, 0, 0, 0, 0, 1);
        return;
      end
      for (s = 0; s < NSEM; s++) if (!in_use[s]) break;
      if (s >= NSEM) begin
        push(cst_pkg::ST_FULL, 0, 0, 0, 0, 0, 1);
        return;
      end
      in_use[s] = 1; count[s] = q.init_value[14:0]; has_waiters[s] = 0;
      push(cst_pkg::ST_OK, s[7:0], 0, 0, 0, 0, 1);
      return;
    end
    if (id >= NSEM || !in_use[id]) begin
      push(cst_pkg::ST_BAD_ID, id[7:0], 0, 0, 0, 0, 1);
      return;
    end
    case (q.op)
      cst_pkg::OP_WAIT: begin
        if (count[id] > 0) begin
          count[id]--;
          push(cst_pkg::ST_OK, id[7:0], 0, 0, 0, 0, 1);
        end else begin
          if (has_waiters[id]) next_proc[tail[id]] = p;
          else begin
            head[id] = p; has_waiters[id] = 1;
          end
          tail[id] = p;
          push(cst_pkg::ST_BLOCKED, id[7:0], 0, 0, 0, 0, 1);
        end
      end
      cst_pkg::OP_SIGNAL: begin
        if (has_waiters[id]) begin
          cur = head[id];
          if (cur == tail[id]) has_waiters[id] = 0;
          else head[id] = next_proc[cur];
          push(cst_pkg::ST_OK, id[7:0], 1, cur, 0, 0, 1);
        end else if (count[id] == cst_pkg::COUNT_MAX) begin
          push(cst_pkg::ST_SATURATED, id[7:0], 0, 0, 0, 0, 1);
        end else begin
          count[id]++;
          push(cst_pkg::ST_OK, id[7:0], 0, 0, 0, 0, 1);
        end
      end
      default: begin
        if (has_waiters[id]) begin
          cur = head[id];
          n = 0;
          do begin
            fin = (cur == tail[id]) || (n + 1 >= cst_pkg::MAX_OUT);
            push(cst_pkg::ST_OK, id[7:0], 1, cur, 1, 1, fin);
            n++;
            cur = next_proc[cur];
          end while (!fin);
        end else begin
          push(cst_pkg::ST_OK, id[7:0], 0, 0, 0, 0, 1);
        end
        in_use[id] = 0; count[id] = 0; has_waiters[id] = 0;
      end
    endcase
  endfunction

  function void check_result(cst_pkg::rsp_t a);
    cst_pkg::rsp_t e;
    if (pending.size() == 0) begin
      $error("unexpected result %p", a);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (a.status !== e.status) begin
      $error("status exp %0d got %0d", e.status, a.status); errors++;
    end
    if (a.result_sem !== e.result_sem) begin
      $error("result_sem exp %0d got %0d", e.result_sem, a.result_sem); errors++;
    end
    if (a.wake_valid !== e.wake_valid) begin
      $error("wake_valid exp %0d got %0d", e.wake_valid, a.wake_valid); errors++;
    end
    if (a.woken_slot !== e.woken_slot) begin
      $error("woken_slot exp %0d got %0d", e.woken_slot, a.woken_slot); errors++;
    end
    if (a.wake_reason !== e.wake_reason) begin
      $error("wake_reason exp %0d got %0d", e.wake_reason, a.wake_reason); errors++;
    end
    if (a.had_waiters !== e.had_waiters) begin
      $error("had_waiters exp %0d got %0d", e.had_waiters, a.had_waiters); errors++;
    end
    if (a.last !== e.last) begin
      $error("last exp %0d got %0d", e.last, a.last); errors++;
    end
  endfunction
endclass

module counting_semaphore_table_tb;
  import cst_pkg::*;

  localparam int WATCHDOG = 200000;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  req_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  rsp_t out_data;

  sem_scoreboard sb;

  // Model-side view of who is queued, so a process slot is never queued twice.
  bit       proc_waiting[32];
  int       proc_sem[32];
  bit       quiet;          // no idling in the final stretch
  bit       hold_off;       // long receiver stall request
  int       idle_cycles = 0;

  always #6 clk = ~clk;

  counting_semaphore_table i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  // Transfers are sampled at the rising edge; the predictor runs on input
  // transfers, the checker on output transfers.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_request(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("counting_semaphore_table_tb: FAIL");
        $finish;
      end
    end
  end

  // Receiver: random stall bursts, or one long hold-off on request.
  initial begin : receiver
    int k;
    bit held;
    held = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off && !held) begin
        out_ready <= 0;
        repeat (400) @(negedge clk);
        held = 1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready <= 0;
        k = $urandom_range(1, 9);
        repeat (k) @(negedge clk);
      end else begin
        out_ready <= 1;
        @(negedge clk);
      end
    end
  end

  // Mirror the queue bookkeeping the predictor needs to choose legal slots.
  function automatic int free_proc();
    int c[$];
    for (int i = 0; i < 32; i++) if (!proc_waiting[i]) c.push_back(i);
    if (c.size() == 0) return -1;
    return c[$urandom_range(0, c.size() - 1)];
  endfunction

  // Offer one request, holding it until accepted.
  task automatic send(op_t op, logic [9:0] id, logic signed [15:0] iv, logic [4:0] p);
    int k;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      k = $urandom_range(1, 9);
      repeat (k) @(negedge clk);
    end
    in_data <= '{op: op, sem_id: id, init_value: iv, proc_slot: p};
    in_valid <= 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Wait on a semaphore only when that would not requeue a waiting slot.
  task automatic do_wait(int id);
    int p;
    p = free_proc();
    if (p < 0) return;
    if (id < 256 && sb.in_use[id] && sb.count[id] == 0) begin
      proc_waiting[p] = 1; proc_sem[p] = id;
    end
    send(OP_WAIT, id[9:0], 16'($urandom), p[4:0]);
  endtask

  // Keep waiting flags consistent after a signal or a free.
  task automatic do_signal(int id);
    if (id < 256 && sb.in_use[id] && sb.has_waiters[id]) proc_waiting[sb.head[id]] = 0;
    send(OP_SIGNAL, id[9:0], 16'($urandom), 5'($urandom));
  endtask

  task automatic do_free(int id);
    if (id < 256 && sb.in_use[id])
      for (int i = 0; i < 32; i++) if (proc_waiting[i] && proc_sem[i] == id) proc_waiting[i] = 0;
    send(OP_FREE, id[9:0], 16'($urandom), 5'($urandom));
  endtask

  function automatic int live_sem();
    int c[$];
    for (int i = 0; i < 256; i++) if (sb.in_use[i]) c.push_back(i);
    if (c.size() == 0) return 0;
    return c[$urandom_range(0, c.size() - 1)];
  endfunction

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  initial begin : sender
    int id, r;
    sb = new();
    repeat (11) @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // Directed: create extremes, bad init, bad ids, saturation, blocking, wakes.
    send(OP_CREATE, 10'h3ff, 16'sh7fff, 5'd31);          // slot 0, count max
    send(OP_CREATE, 10'd0, 16'sh8000, 5'd0);             // most negative: bad init
    send(OP_CREATE, 10'd0, -16'sd1, 5'd0);               // bad init
    send(OP_CREATE, 10'd0, 16'sd0, 5'd0);                // slot 1, count zero
    do_signal(0);                                        // saturated
    do_wait(0);
    do_signal(0);
    do_wait(1); do_wait(1); do_wait(1);                  // three blocked
    do_signal(1);                                        // wakes oldest
    do_signal(5);                                        // not allocated
    do_wait(10'h3ff);                                    // out of range
    do_free(10'h200);
    do_free(1);                                          // free walks waiters
    do_free(1);                                          // now bad id
    do_free(0);                                          // free, no waiters
    send(OP_CREATE, 10'd0, 16'sd0, 5'd0);
    for (int i = 0; i < 32; i++) do_wait(0);             // every process slot queued
    do_free(0);                                          // longest walk
    drain();

    // Random: mostly legal traffic on live semaphores, some noise.
    for (int n = 0; n < 80; n++) begin
      if (n == 20) hold_off = 1;
      if (n == 65) quiet = 1;
      r = $urandom_range(0, 99);
      id = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : live_sem();
      if (r < 12) send(OP_CREATE, 10'($urandom), ($urandom_range(0, 7) == 0) ?
                       16'($urandom) : 16'($urandom_range(0, 2)), 5'($urandom));
      else if (r < 50) do_wait(id);
      else if (r < 85) do_signal(id);
      else do_free(id);
    end
    drain();
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("counting_semaphore_table_tb: PASS");
    else
      $display("counting_semaphore_table_tb: FAIL");
    $finish;
  end
endmodule

// ===== counting_semaphore_table.f =====
hdl/cst_pkg.sv
hdl/cst_ram.sv
hdl/counting_semaphore_table.sv
verif/counting_semaphore_table_tb.sv
